@@ rtl/lfu_pkg.sv @@
// lfu_pkg: types and codes shared by the cache cells, the sequencer and the top level
// depends on nothing; every other file refers to it by scoped names
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 64;
	localparam int USED_W  = 5;

	// sweep token, handed from cell to cell once per request
	typedef struct packed {
		logic               vld;
		logic               found;
		logic [VAL_W-1:0]   found_val;
		logic               free;
		logic               vic;
		logic [CNT_W-1:0]   vic_cnt;
		logic [STAMP_W-1:0] vic_stamp;
		logic [KEY_W-1:0]   vic_key;
		logic [USED_W-1:0]  used;
	} lfu_tok_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TOUCH,
		CMD_WRITE,
		CMD_REPLACE,
		CMD_FILL
	} lfu_cmd_t;

	// update broadcast to all cells at the end of a request
	typedef struct packed {
		lfu_cmd_t           op;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
		logic [KEY_W-1:0]   vic_key;
	} lfu_upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} lfu_state_t;

endpackage

@@ rtl/lfu_cell.sv @@
// lfu_cell: one cache entry with its key compare and one step of the victim search
// depends on lfu_pkg for the token and update types
module lfu_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lfu_pkg::KEY_W-1:0]    req_key,
	input  lfu_pkg::lfu_tok_t            tok_i,
	output lfu_pkg::lfu_tok_t            tok_o,
	input  lfu_pkg::lfu_upd_t            upd
);

	logic [lfu_pkg::KEY_W-1:0]   key_q;
	logic [lfu_pkg::VAL_W-1:0]   val_q;
	logic [lfu_pkg::CNT_W-1:0]   cnt_q;
	logic [lfu_pkg::STAMP_W-1:0] stamp_q;
	logic                        valid_q;
	logic                        first_free_q;
	lfu_pkg::lfu_tok_t           tok_q;
	lfu_pkg::lfu_tok_t           tok_d;
	logic                        better;
	logic                        upd_match;
	logic                        vic_match;
	logic [lfu_pkg::CNT_W-1:0]   cnt_inc;

	assign better = !tok_i.vic || (cnt_q < tok_i.vic_cnt) ||
		((cnt_q == tok_i.vic_cnt) && (stamp_q < tok_i.vic_stamp));

	always_comb begin
		tok_d = tok_i;
		if (tok_i.vld) begin
			if (valid_q) begin
				if (tok_i.used != '1)
					tok_d.used = tok_i.used + 1'b1;
				if ((key_q == req_key) && !tok_i.found) begin
					tok_d.found     = 1'b1;
					tok_d.found_val = val_q;
				end
				if (better) begin
					tok_d.vic       = 1'b1;
					tok_d.vic_cnt   = cnt_q;
					tok_d.vic_stamp = stamp_q;
					tok_d.vic_key   = key_q;
				end
			end else begin
				tok_d.free = 1'b1;
			end
		end
	end

	assign tok_o     = tok_q;
	assign upd_match = valid_q && (key_q == upd.key);
	assign vic_match = valid_q && (key_q == upd.vic_key);
	// use count saturates
	assign cnt_inc   = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q        <= '0;
			valid_q      <= 1'b0;
			first_free_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			if (tok_i.vld)
				first_free_q <= !valid_q && !tok_i.free;
			if ((upd.op == lfu_pkg::CMD_FILL) && first_free_q)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (upd.op)
			lfu_pkg::CMD_TOUCH: begin
				if (upd_match) begin
					cnt_q   <= cnt_inc;
					stamp_q <= upd.stamp;
				end
			end
			lfu_pkg::CMD_WRITE: begin
				if (upd_match) begin
					cnt_q   <= cnt_inc;
					stamp_q <= upd.stamp;
					val_q   <= upd.value;
				end
			end
			lfu_pkg::CMD_REPLACE: begin
				if (vic_match) begin
					key_q   <= upd.key;
					val_q   <= upd.value;
					cnt_q   <= lfu_pkg::CNT_W'(1);
					stamp_q <= upd.stamp;
				end
			end
			lfu_pkg::CMD_FILL: begin
				if (first_free_q) begin
					key_q   <= upd.key;
					val_q   <= upd.value;
					cnt_q   <= lfu_pkg::CNT_W'(1);
					stamp_q <= upd.stamp;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/lfu_seq.sv @@
// lfu_seq: request sequencer, capacity register, update decision and output register
// depends on lfu_pkg for the token, update and state types
module lfu_seq #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [4:0]                    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [63:0]                   m_tdata,
	output logic [1:0]                    m_tuser,
	output logic [lfu_pkg::KEY_W-1:0]     req_key,
	output lfu_pkg::lfu_tok_t             tok_start,
	input  lfu_pkg::lfu_tok_t             tok_last,
	output lfu_pkg::lfu_upd_t             upd
);

	localparam logic [4:0] CAP_LIM = 5'((CAPACITY > 31) ? 31 : CAPACITY);

	lfu_pkg::lfu_state_t         state_q, state_d;
	logic [4:0]                  cap_q;
	logic [lfu_pkg::STAMP_W-1:0] op_cnt_q;
	logic                        func_q;
	logic [lfu_pkg::KEY_W-1:0]   key_q;
	logic [lfu_pkg::VAL_W-1:0]   val_q;
	logic                        start_q;
	lfu_pkg::lfu_tok_t           fin_q;
	logic                        out_valid_q;
	logic                        hit_q;
	logic                        evicted_q;
	logic [31:0]                 read_value_q;
	logic [31:0]                 evicted_key_q;
	logic [4:0]                  lim;
	logic                        accept;
	logic                        fire;
	logic                        ev;
	logic [31:0]                 rd;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		lim = cap_q;
		if (lim == 5'd0)
			lim = 5'd1;
		if (lim > CAP_LIM)
			lim = CAP_LIM;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfu_pkg::ST_IDLE:  if (accept) state_d = lfu_pkg::ST_SWEEP;
			lfu_pkg::ST_SWEEP: if (tok_last.vld) state_d = lfu_pkg::ST_DONE;
			lfu_pkg::ST_DONE:  if (fire) state_d = lfu_pkg::ST_IDLE;
			default:           state_d = lfu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == lfu_pkg::ST_IDLE);
		fire          = (state_q == lfu_pkg::ST_DONE) && (!out_valid_q || m_tready);
		ev            = 1'b0;
		rd            = '0;
		upd.op        = lfu_pkg::CMD_NONE;
		upd.key       = key_q;
		upd.value     = val_q;
		upd.stamp     = op_cnt_q;
		upd.vic_key   = fin_q.vic_key;
		if (fin_q.found) begin
			if (func_q) begin
				upd.op = lfu_pkg::CMD_WRITE;
			end else begin
				upd.op = lfu_pkg::CMD_TOUCH;
				rd     = fin_q.found_val;
			end
		end else if (func_q) begin
			if ((fin_q.used >= lim) && fin_q.vic) begin
				ev     = 1'b1;
				upd.op = lfu_pkg::CMD_REPLACE;
			end else if (fin_q.free) begin
				upd.op = lfu_pkg::CMD_FILL;
			end
		end
		if (!fire)
			upd.op = lfu_pkg::CMD_NONE;
		tok_start     = '0;
		tok_start.vld = start_q;
	end

	assign req_key  = key_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {evicted_key_q, read_value_q};
	assign m_tuser  = {evicted_q, hit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfu_pkg::ST_IDLE;
			cap_q       <= 5'd16;
			op_cnt_q    <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept;
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (accept)
				op_cnt_q <= op_cnt_q + 1'b1;
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser;
			key_q  <= s_tdata[31:0];
			val_q  <= s_tdata[63:32];
		end
		if (tok_last.vld)
			fin_q <= tok_last;
		if (fire) begin
			hit_q         <= fin_q.found;
			read_value_q  <= rd;
			evicted_q     <= ev;
			evicted_key_q <= ev ? fin_q.vic_key : 32'd0;
		end
	end

	a_tok_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.vld |-> (state_q == lfu_pkg::ST_SWEEP))
		else $error("sweep token left the chain outside a sweep");

	a_evict_on_put_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ev) |-> (func_q && !fin_q.found))
		else $error("eviction on a hit or on a get");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == lfu_pkg::ST_SWEEP) && start_q)
		else $error("accepted word did not start a sweep");

	a_fire_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result lost at output register");

endmodule

@@ rtl/lfu_cache_table.sv @@
// lfu_cache_table: fully associative lfu cache with lru tie-break, built as a chain of cells
// depends on lfu_pkg, lfu_cell and lfu_seq
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: req_key, req_value; tuser: func
//  m_*      out  m_tvalid/m_tready    tdata: read_value, evicted_key; tuser: hit, evicted
//  cfg_*    in   cfg_we               cfg_wdata: capacity_in_use
//
// for each request a token walks the cell chain one cell a cycle,
// then the sequencer decides and broadcasts the update to all cells
// one request in flight at a time; the next word is taken while a result waits at m_*
// reset clears valid marks, the operation counter and sets the capacity register to 16
// a stall on m_* holds the next result in the done state until the output register frees
module lfu_cache_table #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // req_key [31:0], req_value [63:32]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // read_value [31:0], evicted_key [63:32]
	output logic [1:0]  m_tuser    // hit [0], evicted [1]
);

	lfu_pkg::lfu_tok_t         tok [CAPACITY+1];
	lfu_pkg::lfu_upd_t         upd;
	logic [lfu_pkg::KEY_W-1:0] req_key;

	lfu_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.req_key   (req_key),
		.tok_start (tok[0]),
		.tok_last  (tok[CAPACITY]),
		.upd       (upd)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lfu_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req_key (req_key),
			.tok_i   (tok[i]),
			.tok_o   (tok[i+1]),
			.upd     (upd)
		);
	end

endmodule
